// ===== src/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg
// Shared constants for the photon centroid and time histogram block.
// ----------------------------------------------------------------------------
package pct_pkg;

   localparam int NumBins  = 64;
   localparam int BinAw    = (NumBins > 1) ? $clog2(NumBins) : 1;

   localparam int CountW   = 16;
   localparam int PosW     = 24;
   localparam int SumW     = 64;
   localparam int CntW     = 32;
   localparam int EnergyW  = 48;
   localparam int BinIdxW  = 6;

   localparam int ReqDataW = 112;
   localparam int RspDataW = 224;

   localparam int DivSteps = 64;
   localparam int DivCntW  = $clog2(DivSteps);

   localparam logic [31:0] CalReset = 32'h0001_0000;

   typedef enum logic {
      CMD_ADD      = 1'b0,
      CMD_FINALIZE = 1'b1
   } cmd_type;

endpackage

// ===== src/pct_ram.sv =====
// ----------------------------------------------------------------------------
// pct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pct_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                       wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                       rd_data
);

   logic [Width-1:0] mem_ff [0:Depth-1];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pct_divider.sv =====
// ----------------------------------------------------------------------------
// pct_divider
// Restoring divider, 64-bit magnitude by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pct_divider
   import pct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SumW-1:0] dividend,
   input  logic [CntW-1:0] divisor,
   output logic            busy,
   output logic            done,
   output logic [SumW-1:0] quotient
);

   logic               busy_ff;
   logic               done_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic [SumW-1:0]    work_ff;
   logic [CntW-1:0]    rem_ff;
   logic [CntW-1:0]    divisor_ff;

   logic [CntW:0]      rem_sh;
   logic [CntW:0]      rem_diff;
   logic               ge;
   logic [CntW-1:0]    rem_in;

   always_comb begin
      rem_sh   = {rem_ff, work_ff[SumW-1]};
      ge       = rem_sh >= {1'b0, divisor_ff};
      rem_diff = rem_sh - {1'b0, divisor_ff};
      rem_in   = ge ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            cnt_ff     <= '0;
            work_ff    <= dividend;
            rem_ff     <= '0;
            divisor_ff <= divisor;
         end else if (busy_ff) begin
            work_ff <= {work_ff[SumW-2:0], ge};
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(DivSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ===== src/photon_centroid_time_histogram.sv =====
// ----------------------------------------------------------------------------
// photon_centroid_time_histogram
// Photon deposit accumulator with weighted centroid and arrival time histogram.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel. An add request (tuser 0) adds the
// photon count to the totals, the count-weighted x, y and z to three signed
// sums and the count to time bin floor(t/64) when that bin lies in the window.
// A finalize request (tuser 1) produces NumBins results on the rsp_ channel,
// one per bin in rising order, tlast on the final one, and then clears all
// accumulators. The calibration factor is written on the csr_ channel.
// Sequencing: an add request runs one shared multiplier and one 64-bit
// saturating adder over the three axes in turn, then one bin read-modify-
// write. A finalize computes the energy, then the three means through the
// bit-serial divider (skipped when the total is zero), then reads the
// histogram memory once for each bin.
// Reset sets the factor to 1.0 and marks every bin empty at once through
// per-bin valid flags. One result register sits on the output; while the
// receiver stalls, the sequencer holds before loading the next bin and
// req_tready stays low until the run is done.
// ----------------------------------------------------------------------------
module photon_centroid_time_histogram
   import pct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   // photon_count, pos_x, pos_y, pos_z, arrival_time
   input  logic [ReqDataW-1:0] req_tdata,
   // command
   input  logic                req_tuser,
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // mean_x, mean_y, mean_z, energy, total_photons, step_total,
   // bin_index, bin_photons, zero pad
   output logic [RspDataW-1:0] rsp_tdata,
   // empty_flag
   output logic                rsp_tuser,
   output logic                rsp_tlast,
   // calibration register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_BIN,
      ST_ENERGY,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FETCH,
      ST_LOAD
   } state_type;

   state_type           state_ff;
   logic [31:0]         cal_ff;
   logic [CntW-1:0]     photon_sum_ff;
   logic [CntW-1:0]     step_sum_ff;
   logic [SumW-1:0]     wsum_ff [0:2];
   logic [PosW-1:0]     pos_ff [0:2];
   logic [CountW-1:0]   count_ff;
   logic                bin_hit_ff;
   logic [BinAw-1:0]    addr_ff;
   logic [1:0]          axis_ff;
   logic [SumW-1:0]     prod_ff;
   logic [EnergyW-1:0]  energy_ff;
   logic [PosW-1:0]     mean_ff [0:2];
   logic                neg_ff;
   logic [NumBins-1:0]  valid_ff;
   logic                rd_valid_ff;

   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;
   logic                rsp_user_ff;
   logic                rsp_last_ff;

   // request fields
   logic [CountW-1:0]   req_count;
   logic [PosW-1:0]     req_pos [0:2];
   logic [PosW-1:0]     req_time;
   logic                req_accept;

   assign req_count  = req_tdata[15:0];
   assign req_pos[0] = req_tdata[39:16];
   assign req_pos[1] = req_tdata[63:40];
   assign req_pos[2] = req_tdata[87:64];
   assign req_time   = req_tdata[111:88];
   assign req_accept = req_tvalid && req_tready;

   // shared multiplier
   logic signed [32:0]  mul_a;
   logic signed [32:0]  mul_b;
   logic signed [65:0]  mul_full;

   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = {{9{pos_ff[axis_ff][PosW-1]}}, pos_ff[axis_ff]};
         mul_b = {17'b0, count_ff};
      end else begin
         mul_a = {1'b0, photon_sum_ff};
         mul_b = {1'b0, cal_ff};
      end
      mul_full = mul_a * mul_b;
   end

   // shared saturating adder
   logic [SumW-1:0]     acc_a;
   logic [SumW-1:0]     acc_sum;
   logic [SumW-1:0]     wsum_in;

   always_comb begin
      acc_a   = wsum_ff[axis_ff];
      acc_sum = acc_a + prod_ff;
      if (acc_a[SumW-1] == prod_ff[SumW-1] && acc_sum[SumW-1] != acc_a[SumW-1]) begin
         wsum_in = acc_a[SumW-1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         wsum_in = acc_sum;
      end
   end

   // totals
   logic [CntW:0]       photon_wide;
   logic [CntW:0]       step_wide;
   logic [CntW-1:0]     photon_in;
   logic [CntW-1:0]     step_in;

   always_comb begin
      photon_wide = {1'b0, photon_sum_ff} + {17'b0, req_count};
      step_wide   = {1'b0, step_sum_ff} + {{CntW{1'b0}}, 1'b1};
      photon_in   = photon_wide[CntW] ? {CntW{1'b1}} : photon_wide[CntW-1:0];
      step_in     = step_wide[CntW] ? {CntW{1'b1}} : step_wide[CntW-1:0];
   end

   // histogram memory
   logic [CntW-1:0]     ram_rd_data;
   logic [CntW-1:0]     bin_old;
   logic [CntW:0]       bin_wide;
   logic [CntW-1:0]     bin_in;
   logic                ram_wr_en;

   assign bin_old   = rd_valid_ff ? ram_rd_data : '0;
   assign bin_wide  = {1'b0, bin_old} + {17'b0, count_ff};
   assign bin_in    = bin_wide[CntW] ? {CntW{1'b1}} : bin_wide[CntW-1:0];
   assign ram_wr_en = (state_ff == ST_BIN) && bin_hit_ff;

   pct_ram #(
      .Width (CntW),
      .Depth (NumBins)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (bin_in),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // divider for the means
   logic                div_start;
   logic                div_busy;
   logic                div_done;
   logic [SumW-1:0]     div_quot;
   logic [SumW-1:0]     div_mag;
   logic [PosW-1:0]     mean_in;

   assign div_start = state_ff == ST_DIV_START;
   assign div_mag   = wsum_ff[axis_ff][SumW-1] ? (~wsum_ff[axis_ff] + 1'b1) : wsum_ff[axis_ff];

   pct_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (photon_sum_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      if (neg_ff) begin
         mean_in = (div_quot > 64'd8388608) ? 24'h800000 : -div_quot[PosW-1:0];
      end else begin
         mean_in = (div_quot > 64'd8388607) ? 24'h7FFFFF : div_quot[PosW-1:0];
      end
   end

   logic                rsp_free;
   logic                rsp_load;
   logic                load_last;
   logic                req_bin_hit;

   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_load    = (state_ff == ST_LOAD) && rsp_free;
   assign load_last   = addr_ff == BinAw'(NumBins - 1);
   assign req_bin_hit = !req_time[PosW-1] && ({15'b0, req_time[22:6]} < 32'(NumBins));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cal_ff        <= CalReset;
         photon_sum_ff <= '0;
         step_sum_ff   <= '0;
         wsum_ff[0]    <= '0;
         wsum_ff[1]    <= '0;
         wsum_ff[2]    <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         axis_ff       <= '0;
         addr_ff       <= '0;
      end else begin
         rd_valid_ff <= valid_ff[addr_ff];
         if (csr_valid) begin
            cal_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  axis_ff <= '0;
                  if (cmd_type'(req_tuser) == CMD_ADD) begin
                     photon_sum_ff <= photon_in;
                     step_sum_ff   <= step_in;
                     count_ff      <= req_count;
                     pos_ff[0]     <= req_pos[0];
                     pos_ff[1]     <= req_pos[1];
                     pos_ff[2]     <= req_pos[2];
                     bin_hit_ff    <= req_bin_hit;
                     addr_ff       <= req_time[6 +: BinAw];
                     state_ff      <= ST_MUL;
                  end else begin
                     state_ff <= ST_ENERGY;
                  end
               end
            end
            ST_MUL: begin
               prod_ff  <= mul_full[SumW-1:0];
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               wsum_ff[axis_ff] <= wsum_in;
               if (axis_ff == 2'd2) begin
                  state_ff <= ST_BIN;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_BIN: begin
               if (bin_hit_ff) begin
                  valid_ff[addr_ff] <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            ST_ENERGY: begin
               prod_ff <= mul_full[SumW-1:0];
               if (photon_sum_ff == '0) begin
                  mean_ff[0] <= '0;
                  mean_ff[1] <= '0;
                  mean_ff[2] <= '0;
                  addr_ff    <= '0;
                  state_ff   <= ST_FETCH;
               end else begin
                  state_ff <= ST_DIV_START;
               end
            end
            ST_DIV_START: begin
               neg_ff   <= wsum_ff[axis_ff][SumW-1];
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  mean_ff[axis_ff] <= mean_in;
                  if (axis_ff == 2'd2) begin
                     addr_ff  <= '0;
                     state_ff <= ST_FETCH;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= ST_DIV_START;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (rsp_free) begin
                  rsp_user_ff  <= photon_sum_ff == '0;
                  rsp_last_ff  <= load_last;
                  rsp_data_ff  <= {2'b00, bin_old, BinIdxW'(addr_ff), step_sum_ff,
                                   photon_sum_ff, energy_ff,
                                   mean_ff[2], mean_ff[1], mean_ff[0]};
                  if (load_last) begin
                     photon_sum_ff <= '0;
                     step_sum_ff   <= '0;
                     wsum_ff[0]    <= '0;
                     wsum_ff[1]    <= '0;
                     wsum_ff[2]    <= '0;
                     valid_ff      <= '0;
                     state_ff      <= ST_IDLE;
                  end else begin
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // energy saturation, kept apart from the sequencer since prod_ff holds during finalize
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH && addr_ff == '0) begin
         energy_ff <= (prod_ff[SumW-1:EnergyW] != '0) ? {EnergyW{1'b1}} : prod_ff[EnergyW-1:0];
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // no request is taken while the divider is still running
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !div_busy)
      else $error("request accepted while divider busy");

   // the final result of a run always carries the top bin
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[189:184] == BinIdxW'(NumBins - 1))
      else $error("tlast on a result other than the top bin");

   // accumulators are clear once the top bin has been loaded
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD && rsp_free && load_last |=> photon_sum_ff == '0 && valid_ff == '0)
      else $error("accumulators not cleared after finalize");

endmodule

// ===== tb/tb_photon_centroid_time_histogram.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_photon_centroid_time_histogram
// Drives photon deposits and finalize requests with random gaps and stalls,
// predicts every bin result of each run and checks it field by field.
// ----------------------------------------------------------------------------
module tb_photon_centroid_time_histogram;
   import pct_pkg::*;

   localparam int     SettleCycles = 24;
   localparam longint SumMax       = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SumMin       = 64'sh8000_0000_0000_0000;

   typedef struct {
      logic [23:0] mean_x;
      logic [23:0] mean_y;
      logic [23:0] mean_z;
      logic [47:0] energy;
      logic [31:0] total_photons;
      logic [31:0] step_total;
      logic [5:0]  bin_index;
      logic [31:0] bin_photons;
      logic        empty_flag;
      logic        last;
   } bin_result_type;

   typedef struct {
      logic           csr;
      cmd_type        cmd;
      logic [15:0]    count;
      logic [23:0]    x;
      logic [23:0]    y;
      logic [23:0]    z;
      logic [23:0]    t;
      logic [31:0]    cal;
      logic           quiet;
      logic           typed;
      bin_result_type want;
      logic [5:0]     hot_bin;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [31:0]         csr_data;

   // predictor state
   logic [31:0] cal_shadow;
   logic [31:0] photon_total;
   logic [31:0] add_count;
   longint      wsum_x;
   longint      wsum_y;
   longint      wsum_z;
   logic [31:0] bin_store [NumBins];

   bin_result_type expected_bins[$];
   stim_row_type   plan[$];
   logic           plan_quiet = 1'b0;
   logic           no_gaps = 1'b0;
   int             mismatches = 0;

   photon_centroid_time_histogram uut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic longint sat_add64(longint a, longint b);
      if (b > 0 && a > SumMax - b) return SumMax;
      if (b < 0 && a < SumMin - b) return SumMin;
      return a + b;
   endfunction

   function automatic logic [23:0] mean_of(longint wsum, logic [31:0] n);
      longint d;
      longint q;
      if (n == 0) return '0;
      d = longint'({32'b0, n});
      q = wsum / d;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      return q[23:0];
   endfunction

   function automatic void clear_accumulators();
      photon_total = '0;
      add_count    = '0;
      wsum_x       = 0;
      wsum_y       = 0;
      wsum_z       = 0;
      foreach (bin_store[k]) bin_store[k] = '0;
   endfunction

   function automatic void predict_request(cmd_type cmd, logic [ReqDataW-1:0] d,
                                           stim_row_type row);
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [23:0] pz;
      logic signed [23:0] pt;
      longint             c;
      int                 bin;
      logic [63:0]        e;
      logic [23:0]        mx;
      logic [23:0]        my;
      logic [23:0]        mz;
      bin_result_type     r;
      if (cmd == CMD_ADD) begin
         px = d[39:16];
         py = d[63:40];
         pz = d[87:64];
         pt = d[111:88];
         c  = longint'({48'b0, d[15:0]});
         photon_total = sat_add32(photon_total, {16'b0, d[15:0]});
         add_count    = sat_add32(add_count, 32'd1);
         wsum_x = sat_add64(wsum_x, longint'(px) * c);
         wsum_y = sat_add64(wsum_y, longint'(py) * c);
         wsum_z = sat_add64(wsum_z, longint'(pz) * c);
         // negative time and times past the window only reach the totals
         if (pt >= 0) begin
            bin = int'(pt) >> 6;
            if (bin < NumBins) bin_store[bin] = sat_add32(bin_store[bin], {16'b0, d[15:0]});
         end
      end else begin
         mx = mean_of(wsum_x, photon_total);
         my = mean_of(wsum_y, photon_total);
         mz = mean_of(wsum_z, photon_total);
         e  = {32'b0, photon_total} * {32'b0, cal_shadow};
         if (e > 64'h0000_FFFF_FFFF_FFFF) e = 64'h0000_FFFF_FFFF_FFFF;
         for (int k = 0; k < NumBins; k++) begin
            r.mean_x        = mx;
            r.mean_y        = my;
            r.mean_z        = mz;
            r.energy        = e[47:0];
            r.total_photons = photon_total;
            r.step_total    = add_count;
            r.bin_index     = 6'(k);
            r.bin_photons   = bin_store[k];
            r.empty_flag    = (photon_total == 0);
            r.last          = (k == NumBins - 1);
            if (row.typed) begin
               r.mean_x        = row.want.mean_x;
               r.mean_y        = row.want.mean_y;
               r.mean_z        = row.want.mean_z;
               r.energy        = row.want.energy;
               r.total_photons = row.want.total_photons;
               r.step_total    = row.want.step_total;
               r.bin_photons   = (k == row.hot_bin) ? row.want.bin_photons : '0;
               r.empty_flag    = row.want.empty_flag;
            end
            expected_bins = {expected_bins, r};
         end
         clear_accumulators();
      end
   endfunction

   function automatic void add_row(logic [15:0] n, logic [23:0] x, logic [23:0] y,
                                   logic [23:0] z, logic [23:0] t);
      stim_row_type r;
      r.csr   = 1'b0;
      r.cmd   = CMD_ADD;
      r.count = n;
      r.x     = x;
      r.y     = y;
      r.z     = z;
      r.t     = t;
      r.quiet = plan_quiet;
      r.typed = 1'b0;
      plan = {plan, r};
   endfunction

   function automatic void finalize_row();
      stim_row_type r;
      r.csr   = 1'b0;
      r.cmd   = CMD_FINALIZE;
      r.count = 16'($urandom);
      r.x     = 24'($urandom);
      r.y     = 24'($urandom);
      r.z     = 24'($urandom);
      r.t     = 24'($urandom);
      r.quiet = plan_quiet;
      r.typed = 1'b0;
      plan = {plan, r};
   endfunction

   function automatic void typed_finalize(logic [23:0] mx, logic [23:0] my,
                                          logic [23:0] mz, logic [47:0] energy,
                                          logic [31:0] total, logic [31:0] steps,
                                          logic [5:0] hot, logic [31:0] hot_val,
                                          logic empty);
      stim_row_type r;
      r.csr                = 1'b0;
      r.cmd                = CMD_FINALIZE;
      r.count              = '0;
      r.x                  = '0;
      r.y                  = '0;
      r.z                  = '0;
      r.t                  = '0;
      r.quiet              = plan_quiet;
      r.typed              = 1'b1;
      r.want.mean_x        = mx;
      r.want.mean_y        = my;
      r.want.mean_z        = mz;
      r.want.energy        = energy;
      r.want.total_photons = total;
      r.want.step_total    = steps;
      r.want.bin_photons   = hot_val;
      r.want.empty_flag    = empty;
      r.hot_bin            = hot;
      plan = {plan, r};
   endfunction

   function automatic void cal_row(logic [31:0] v);
      stim_row_type r;
      r.csr   = 1'b1;
      r.cmd   = CMD_ADD;
      r.cal   = v;
      r.quiet = plan_quiet;
      r.typed = 1'b0;
      plan = {plan, r};
   endfunction

   function automatic logic [23:0] rand_pos();
      if ($urandom_range(3) == 0) return 24'(int'($urandom_range(2000)) - 1000);
      return 24'($urandom);
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_row(input stim_row_type row);
      logic [ReqDataW-1:0] d;
      no_gaps = row.quiet;
      if (row.csr) begin
         wait_drained();
         csr_valid <= 1'b1;
         csr_data  <= row.cal;
         do @(posedge clock); while (!csr_ready);
         cal_shadow = row.cal;
         csr_valid <= 1'b0;
      end else begin
         d = {row.t, row.z, row.y, row.x, row.count};
         req_tvalid <= 1'b1;
         req_tdata  <= d;
         req_tuser  <= row.cmd;
         do @(posedge clock); while (!req_tready);
         predict_request(row.cmd, d, row);
         if (!row.quiet && $urandom_range(99) < 19) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 19);
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      bin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bins.size() == 0) begin
            $error("unexpected request result, bin_index %0d", rsp_tdata[189:184]);
            mismatches++;
         end else begin
            want = expected_bins.pop_front();
            check_field("mean_x", 64'(want.mean_x), 64'(rsp_tdata[23:0]));
            check_field("mean_y", 64'(want.mean_y), 64'(rsp_tdata[47:24]));
            check_field("mean_z", 64'(want.mean_z), 64'(rsp_tdata[71:48]));
            check_field("energy", 64'(want.energy), 64'(rsp_tdata[119:72]));
            check_field("total_photons", 64'(want.total_photons), 64'(rsp_tdata[151:120]));
            check_field("step_total", 64'(want.step_total), 64'(rsp_tdata[183:152]));
            check_field("bin_index", 64'(want.bin_index), 64'(rsp_tdata[189:184]));
            check_field("bin_photons", 64'(want.bin_photons), 64'(rsp_tdata[221:190]));
            check_field("empty_flag", 64'(want.empty_flag), 64'(rsp_tuser));
            check_field("last", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   initial begin
      int          items;
      int          phase;
      int          nadds;
      logic [15:0] n;
      logic [23:0] t;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_ADD;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      cal_shadow = CalReset;
      clear_accumulators();

      // directed: empty store after reset, field extremes, time edges, energy limits
      typed_finalize('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
      add_row(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000);
      typed_finalize(24'h7FFFFF, 24'h800000, '0, 48'h0000_FFFF_0000, 32'd65535, 32'd1,
                     6'd0, 32'd65535, 1'b0);
      // zero photons with negative time: one step, nothing else
      add_row(16'h0000, 24'h123456, 24'hABCDEF, 24'h7FFFFF, 24'hFFFFFF);
      typed_finalize('0, '0, '0, '0, '0, 32'd1, 6'd0, '0, 1'b1);
      add_row(16'd100, -24'sd300, 24'sd1000, 24'h800000, 24'h800000);
      add_row(16'd50, 24'sd7, -24'sd3, 24'sd5, 24'h7FFFFF);
      add_row(16'd3, -24'sd1, 24'sd2, -24'sd9, 24'd4095);
      add_row(16'd1, 24'sd11, 24'sd11, 24'sd11, 24'd4096);
      add_row(16'd7, '0, '0, '0, 24'd64);
      finalize_row();
      cal_row(32'hFFFF_FFFF);
      add_row(16'hFFFF, '0, '0, '0, 24'd63);
      add_row(16'hFFFF, '0, '0, '0, 24'd0);
      typed_finalize('0, '0, '0, 48'hFFFF_FFFF_FFFF, 32'd131070, 32'd2, 6'd0,
                     32'd131070, 1'b0);
      cal_row(32'h0000_0000);
      add_row(16'd1234, -24'sd5, 24'sd5, 24'h800000, 24'd200);
      finalize_row();
      cal_row(CalReset);

      // random runs of deposits, each closed by a finalize
      items = 0;
      phase = 0;
      while (items < 160) begin
         plan_quiet = (phase >= 5 && phase <= 7);
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(3))
               0:       cal_row($urandom);
               1:       cal_row(CalReset);
               2:       cal_row(32'hFFFF_FFFF);
               default: cal_row($urandom_range(0, 200000));
            endcase
         end
         nadds = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 14);
         for (int i = 0; i < nadds; i++) begin
            case ($urandom_range(7))
               0:       n = 16'h0000;
               1:       n = 16'hFFFF;
               2, 3:    n = 16'($urandom_range(1, 50));
               default: n = 16'($urandom);
            endcase
            case ($urandom_range(9))
               0:       t = {1'b1, 23'($urandom)};
               1:       t = 24'($urandom_range(4096, 8388607));
               default: t = 24'($urandom_range(0, 4095));
            endcase
            add_row(n, rand_pos(), rand_pos(), rand_pos(), t);
         end
         finalize_row();
         items += nadds + 1;
         phase++;
      end
      plan_quiet = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) run_row(plan[i]);
      wait_drained();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
